// ===== src/brle_pkg.sv =====
// shared types and constants for the byte run-length encoder
package brle_pkg;

   localparam int BYTE_W        = 8;
   localparam int WORD_W        = 64;
   localparam int COUNT_W       = 4;
   localparam int RUN_LEN_W     = 8;
   localparam int LITERAL_DEPTH = 128;
   localparam int LIT_IDX_W     = $clog2(LITERAL_DEPTH);
   localparam int LIT_CNT_W     = $clog2(LITERAL_DEPTH + 1);
   localparam int RUN_MIN       = 3;
   localparam int RUN_MAX       = 130;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN_HDR,
      ST_RUN_VAL,
      ST_LIT_HDR,
      ST_LIT_BODY
   } state_type;

   // byte source selected for the packer
   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_RUN_HDR,
      EMIT_RUN_VAL,
      EMIT_LIT_HDR,
      EMIT_LIT_BODY
   } emit_type;

   // groups an item closes, and their order
   typedef struct packed {
      logic run;
      logic lit;
      logic run_first;
   } plan_type;

   // controller to datapath
   typedef struct packed {
      logic     take;
      emit_type sel;
      logic     push;
      logic     burst_done;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      plan_type plan;
      plan_type pend;
      logic     lit_end;
      logic     push_ok;
   } dp_status_type;

endpackage

// ===== src/brle_chan_if.sv =====
// handshake channels for raw bytes in and packed code words out
interface brle_req_if;
   import brle_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              stream_last;
   modport source (output valid, output data_byte, output stream_last, input ready);
   modport sink (input valid, input data_byte, input stream_last, output ready);
endinterface

interface brle_rsp_if;
   import brle_pkg::*;
   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  out_word;
   logic [COUNT_W-1:0] byte_count;
   logic               burst_end;
   logic               stream_end;
   modport source (output valid, output out_word, output byte_count, output burst_end,
                   output stream_end, input ready);
   modport sink (input valid, input out_word, input byte_count, input burst_end,
                 input stream_end, output ready);
endinterface

// ===== src/brle_ctrl.sv =====
// encoder controller: sequences the bytes of the groups an item closes
module brle_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output brle_pkg::dp_cmd_type     cmd,
   input  brle_pkg::dp_status_type  status
);
   import brle_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.plan.run && (status.plan.run_first || !status.plan.lit)) begin
                  state_in = ST_RUN_HDR;
               end else if (status.plan.lit) begin
                  state_in = ST_LIT_HDR;
               end
            end
         end
         ST_RUN_HDR: begin
            if (status.push_ok) state_in = ST_RUN_VAL;
         end
         ST_RUN_VAL: begin
            if (status.push_ok) begin
               if (status.pend.lit && status.pend.run_first) begin
                  state_in = ST_LIT_HDR;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LIT_HDR: begin
            if (status.push_ok) state_in = ST_LIT_BODY;
         end
         ST_LIT_BODY: begin
            if (status.push_ok && status.lit_end) begin
               if (status.pend.run && !status.pend.run_first) begin
                  state_in = ST_RUN_HDR;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      req_ready      = 1'b0;
      cmd.take       = 1'b0;
      cmd.sel        = EMIT_NONE;
      cmd.burst_done = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_RUN_HDR: begin
            cmd.sel = EMIT_RUN_HDR;
         end
         ST_RUN_VAL: begin
            cmd.sel        = EMIT_RUN_VAL;
            cmd.burst_done = !(status.pend.lit && status.pend.run_first);
         end
         ST_LIT_HDR: begin
            cmd.sel = EMIT_LIT_HDR;
         end
         ST_LIT_BODY: begin
            cmd.sel        = EMIT_LIT_BODY;
            cmd.burst_done = status.lit_end && !(status.pend.run && !status.pend.run_first);
         end
         default: begin
            cmd.sel = EMIT_NONE;
         end
      endcase
      cmd.push = (cmd.sel != EMIT_NONE) && status.push_ok;
   end

endmodule

// ===== src/brle_dp.sv =====
// encoder datapath: group state, literal buffer, byte packer and output register
module brle_dp #(
   parameter int LANE_BYTES = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [brle_pkg::BYTE_W-1:0]   data_byte,
   input  logic                          stream_last,
   input  brle_pkg::dp_cmd_type          cmd,
   output brle_pkg::dp_status_type       status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [brle_pkg::WORD_W-1:0]   out_word,
   output logic [brle_pkg::COUNT_W-1:0]  byte_count,
   output logic                          burst_end,
   output logic                          stream_end
);
   import brle_pkg::*;

   localparam int PACK_CNT_W = $clog2(LANE_BYTES + 1);

   // group state
   logic [LIT_CNT_W-1:0] lit_cnt_ff, lit_cnt_in;
   logic [BYTE_W-1:0]    last_ff, last_in;
   logic                 pair_ff, pair_in;
   logic                 in_run_ff, in_run_in;
   logic [RUN_LEN_W-1:0] run_len_ff, run_len_in;

   // groups closed by the current item
   plan_type             plan;
   logic [BYTE_W-1:0]    run_hdr_c;
   logic [BYTE_W-1:0]    run_val_c;
   logic [LIT_CNT_W-1:0] lit_n_c;
   logic                 take_lit;
   logic [LIT_IDX_W-1:0] wr_idx;

   plan_type             pend_ff;
   logic [BYTE_W-1:0]    pend_run_hdr_ff;
   logic [BYTE_W-1:0]    pend_run_val_ff;
   logic [LIT_CNT_W-1:0] pend_lit_n_ff;
   logic                 pend_last_ff;

   // literal buffer
   logic [BYTE_W-1:0]    lit_mem [LITERAL_DEPTH];
   logic [LIT_IDX_W-1:0] idx_ff;
   logic [LIT_IDX_W-1:0] rd_addr;
   logic [BYTE_W-1:0]    rd_data_ff;

   // packer and output register
   logic [BYTE_W-1:0]     emit_byte;
   logic [WORD_W-1:0]     pack_word_ff;
   logic [PACK_CNT_W-1:0] pack_cnt_ff;
   logic [PACK_CNT_W-1:0] cnt_next;
   logic [WORD_W-1:0]     merged;
   logic                  load_out;
   logic                  rsp_valid_ff;
   logic [WORD_W-1:0]     out_word_ff;
   logic [COUNT_W-1:0]    byte_count_ff;
   logic                  burst_end_ff;
   logic                  stream_end_ff;

   // effect of one byte on the open group
   always_comb begin
      lit_cnt_in = lit_cnt_ff;
      last_in    = last_ff;
      pair_in    = pair_ff;
      in_run_in  = in_run_ff;
      run_len_in = run_len_ff;
      plan       = '0;
      run_hdr_c  = '0;
      run_val_c  = last_ff;
      lit_n_c    = '0;
      take_lit   = 1'b1;
      wr_idx     = lit_cnt_ff[LIT_IDX_W-1:0];

      // open run: extend, or close on a mismatch or at the maximum length
      if (in_run_ff) begin
         plan.run_first = 1'b1;
         if (data_byte == last_ff) begin
            take_lit = 1'b0;
            if (run_len_ff == RUN_LEN_W'(RUN_MAX - 1)) begin
               plan.run   = 1'b1;
               run_hdr_c  = BYTE_W'(RUN_MAX - RUN_MIN);
               in_run_in  = 1'b0;
               run_len_in = '0;
            end else begin
               run_len_in = run_len_ff + 1'b1;
            end
         end else begin
            plan.run   = 1'b1;
            run_hdr_c  = BYTE_W'(run_len_ff - RUN_LEN_W'(RUN_MIN));
            in_run_in  = 1'b0;
            run_len_in = '0;
         end
      end

      // literal path: a third equal byte starts a run, a full group closes
      if (take_lit) begin
         if (lit_cnt_ff == '0) begin
            lit_cnt_in = LIT_CNT_W'(1);
            last_in    = data_byte;
            pair_in    = 1'b0;
         end else if (pair_ff && (data_byte == last_ff)) begin
            lit_n_c    = lit_cnt_ff - LIT_CNT_W'(RUN_MIN - 1);
            plan.lit   = (lit_n_c != '0);
            lit_cnt_in = '0;
            pair_in    = 1'b0;
            in_run_in  = 1'b1;
            run_len_in = RUN_LEN_W'(RUN_MIN);
            last_in    = data_byte;
         end else begin
            pair_in = (last_ff == data_byte);
            last_in = data_byte;
            if (lit_cnt_ff == LIT_CNT_W'(LITERAL_DEPTH - 1)) begin
               plan.lit   = 1'b1;
               lit_n_c    = LIT_CNT_W'(LITERAL_DEPTH);
               lit_cnt_in = '0;
               pair_in    = 1'b0;
            end else begin
               lit_cnt_in = lit_cnt_ff + 1'b1;
            end
         end
      end

      // end of stream flushes the open group and clears everything
      if (stream_last) begin
         if (in_run_in) begin
            plan.run  = 1'b1;
            run_hdr_c = BYTE_W'(run_len_in - RUN_LEN_W'(RUN_MIN));
            run_val_c = last_in;
         end else if (lit_cnt_in != '0) begin
            plan.lit = 1'b1;
            lit_n_c  = lit_cnt_in;
         end
         lit_cnt_in = '0;
         last_in    = '0;
         pair_in    = 1'b0;
         in_run_in  = 1'b0;
         run_len_in = '0;
      end
   end

   // group state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lit_cnt_ff <= '0;
         last_ff    <= '0;
         pair_ff    <= 1'b0;
         in_run_ff  <= 1'b0;
         run_len_ff <= '0;
         pend_ff    <= '0;
      end else if (cmd.take) begin
         lit_cnt_ff <= lit_cnt_in;
         last_ff    <= last_in;
         pair_ff    <= pair_in;
         in_run_ff  <= in_run_in;
         run_len_ff <= run_len_in;
         pend_ff    <= plan;
      end
   end

   // pending group fields
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         pend_run_hdr_ff <= run_hdr_c;
         pend_run_val_ff <= run_val_c;
         pend_lit_n_ff   <= lit_n_c;
         pend_last_ff    <= stream_last;
      end
   end

   // literal read index, next entry is fetched as a byte leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.take) begin
         idx_ff <= '0;
      end else if (cmd.push && (cmd.sel == EMIT_LIT_BODY)) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   assign rd_addr = (cmd.push && (cmd.sel == EMIT_LIT_BODY)) ? idx_ff + 1'b1 : idx_ff;

   // literal buffer, one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.take && take_lit) begin
         lit_mem[wr_idx] <= data_byte;
      end
      rd_data_ff <= lit_mem[rd_addr];
   end

   // byte to pack
   always_comb begin
      case (cmd.sel)
         EMIT_RUN_HDR:  emit_byte = pend_run_hdr_ff;
         EMIT_RUN_VAL:  emit_byte = pend_run_val_ff;
         EMIT_LIT_HDR:  emit_byte = BYTE_W'('0 - pend_lit_n_ff);
         EMIT_LIT_BODY: emit_byte = rd_data_ff;
         default:       emit_byte = '0;
      endcase
   end

   assign cnt_next = pack_cnt_ff + 1'b1;
   assign merged   = pack_word_ff | (WORD_W'(emit_byte) << {pack_cnt_ff, 3'b000});
   assign load_out = cmd.push && ((cnt_next == PACK_CNT_W'(LANE_BYTES)) || cmd.burst_done);

   // packer and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pack_cnt_ff  <= '0;
         pack_word_ff <= '0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
         pack_cnt_ff  <= '0;
         pack_word_ff <= '0;
      end else begin
         if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (cmd.push) begin
            pack_word_ff <= merged;
            pack_cnt_ff  <= cnt_next;
         end
      end
   end

   // output word
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_word_ff   <= merged;
         byte_count_ff <= COUNT_W'(cnt_next);
         burst_end_ff  <= cmd.burst_done;
         stream_end_ff <= cmd.burst_done && pend_last_ff;
      end
   end

   // status
   assign status.plan    = plan;
   assign status.pend    = pend_ff;
   assign status.lit_end = (LIT_CNT_W'(idx_ff) == (pend_lit_n_ff - LIT_CNT_W'(1)));
   assign status.push_ok = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign out_word   = out_word_ff;
   assign byte_count = byte_count_ff;
   assign burst_end  = burst_end_ff;
   assign stream_end = stream_end_ff;

endmodule

// ===== src/byte_rle_encoder.sv =====
// byte run-length encoder top level
//
// Raw bytes come in on req_bus, one per item, with stream_last on the final
// byte of a stream. Encoded groups leave on rsp_bus in words of up to
// LANE_BYTES bytes, earliest byte in bits 7:0, byte_count telling how many
// are valid. burst_end marks the last word caused by an input item and
// stream_end the last word of the whole stream.
// An item that only extends an open group gives no word. An item that closes
// groups releases its code bytes (header, run value or buffered literal) one
// at a time through the byte-wide packer and the single read port of the
// literal buffer, so a full literal group sends its header and 128 bytes.
// The first word becomes valid once LANE_BYTES bytes are packed, or earlier
// for a short burst. The next item is taken once all bytes of the current one
// are packed. When rsp_bus stalls, the output register holds its word and
// the packer stops; req_bus waits until the burst has drained.
// Reset clears the group state, the packer and the output valid flag; the
// literal buffer needs no clearing since only entries of the open group are
// read.
module byte_rle_encoder #(
   parameter int LANE_BYTES = 8
) (
   input logic        clock,
   input logic        reset,
   brle_req_if.sink   req_bus,
   brle_rsp_if.source rsp_bus
);
   import brle_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // controller
   brle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath
   brle_dp #(
      .LANE_BYTES (LANE_BYTES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_bus.data_byte),
      .stream_last (req_bus.stream_last),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .out_word    (rsp_bus.out_word),
      .byte_count  (rsp_bus.byte_count),
      .burst_end   (rsp_bus.burst_end),
      .stream_end  (rsp_bus.stream_end)
   );

endmodule

// ===== src/brle_checker.sv =====
// port-level checks for the byte run-length encoder
module brle_checker #(
   parameter int LANE_BYTES = 8
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [brle_pkg::WORD_W-1:0]   out_word,
   input logic [brle_pkg::COUNT_W-1:0]  byte_count,
   input logic                          burst_end,
   input logic                          stream_end
);
   import brle_pkg::*;

   // byte count stays within one lane
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (byte_count != '0) && (byte_count <= COUNT_W'(LANE_BYTES)))
      else $error("byte_count out of range");

   // only the last word of a burst may be partial
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !burst_end |-> (byte_count == COUNT_W'(LANE_BYTES)))
      else $error("partial word inside a burst");

   // bytes above the count are zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((out_word >> {byte_count, 3'b000}) == '0))
      else $error("unused bytes of out_word not zero");

   // end of stream closes a burst
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && stream_end |-> burst_end)
      else $error("stream_end without burst_end");

   // a stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_word) && $stable(byte_count))
      else $error("stalled output word changed");

endmodule

bind byte_rle_encoder brle_checker #(
   .LANE_BYTES (LANE_BYTES)
) u_brle_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .out_word   (rsp_bus.out_word),
   .byte_count (rsp_bus.byte_count),
   .burst_end  (rsp_bus.burst_end),
   .stream_end (rsp_bus.stream_end)
);

// ===== tb/byte_rle_encoder_check.sv =====
// checker that predicts and compares the code words of the byte run-length encoder
`timescale 1ns / 1ps
module byte_rle_encoder_check #(
   parameter int LANE_BYTES = 8
) (
   input  logic clock,
   input  logic reset,
   brle_req_if  req_bus,
   brle_rsp_if  rsp_bus,
   output int   fail_count,
   output int   pending
);
   import brle_pkg::*;

   typedef struct {
      logic [WORD_W-1:0]  word;
      logic [COUNT_W-1:0] count;
      logic               burst_end;
      logic               stream_end;
   } code_word_type;

   // encoder state as the predictor tracks it
   logic [BYTE_W-1:0] lit_buf [LITERAL_DEPTH];
   int                lit_cnt;
   logic [BYTE_W-1:0] prev_byte;
   logic              pair_flag;
   logic              run_open;
   int                run_len;

   // code bytes of the current item, and words still to arrive
   logic [BYTE_W-1:0] code_bytes [$];
   code_word_type     expected_words [$];
   code_word_type     want;

   // literal group: negated count, then the buffered bytes
   function automatic void close_literals();
      if (lit_cnt == 0)
         return;
      code_bytes.push_back(8'(256 - lit_cnt));
      for (int i = 0; i < lit_cnt; i++)
         code_bytes.push_back(lit_buf[i]);
      lit_cnt = 0;
      pair_flag = 1'b0;
   endfunction

   // run group: length minus three, then the value
   function automatic void close_run();
      code_bytes.push_back(8'(run_len - RUN_MIN));
      code_bytes.push_back(prev_byte);
      run_open = 1'b0;
      run_len = 0;
   endfunction

   function automatic void add_literal(input logic [BYTE_W-1:0] b);
      if (lit_cnt == 0) begin
         lit_buf[0] = b;
         lit_cnt = 1;
         prev_byte = b;
         pair_flag = 1'b0;
         return;
      end
      lit_buf[lit_cnt] = b;
      lit_cnt++;
      // third equal byte: the last three literals become a run
      if (pair_flag && b == prev_byte) begin
         lit_cnt -= RUN_MIN;
         close_literals();
         run_open = 1'b1;
         run_len = RUN_MIN;
         prev_byte = b;
         return;
      end
      pair_flag = (prev_byte == b);
      prev_byte = b;
      if (lit_cnt >= LITERAL_DEPTH)
         close_literals();
   endfunction

   // one raw byte in, its expected words queued
   function automatic void encode_byte(input logic [BYTE_W-1:0] b, input logic last);
      logic          taken;
      int            n_words;
      int            n_bytes;
      code_word_type w;
      code_bytes.delete();
      taken = 1'b0;
      if (run_open) begin
         if (b == prev_byte && run_len < RUN_MAX) begin
            run_len++;
            if (run_len >= RUN_MAX)
               close_run();
            taken = 1'b1;
         end else begin
            close_run();
         end
      end
      if (!taken)
         add_literal(b);
      // end of stream flushes the open group and starts over
      if (last) begin
         if (run_open)
            close_run();
         else
            close_literals();
         lit_cnt = 0;
         prev_byte = '0;
         pair_flag = 1'b0;
         run_open = 1'b0;
         run_len = 0;
      end
      // pack into lane words, earliest byte lowest
      n_words = (code_bytes.size() + LANE_BYTES - 1) / LANE_BYTES;
      for (int k = 0; k < n_words; k++) begin
         n_bytes = code_bytes.size() - k * LANE_BYTES;
         if (n_bytes > LANE_BYTES)
            n_bytes = LANE_BYTES;
         w.word = '0;
         for (int j = 0; j < n_bytes; j++)
            w.word[8*j +: 8] = code_bytes[k * LANE_BYTES + j];
         w.count = 4'(n_bytes);
         w.burst_end = (k == n_words - 1);
         w.stream_end = last && (k == n_words - 1);
         expected_words.push_back(w);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         lit_cnt = 0;
         prev_byte = '0;
         pair_flag = 1'b0;
         run_open = 1'b0;
         run_len = 0;
         expected_words.delete();
      end else begin
         // accepted input item
         if (req_bus.valid && req_bus.ready)
            encode_byte(req_bus.data_byte, req_bus.stream_last);
         // accepted result item against the oldest expectation
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_words.size() == 0) begin
               fail_count++;
               $display("%0t: expected no word, got word %h count %0d", $time,
                        rsp_bus.out_word, rsp_bus.byte_count);
            end else begin
               want = expected_words.pop_front();
               if (rsp_bus.out_word !== want.word || rsp_bus.byte_count !== want.count ||
                   rsp_bus.burst_end !== want.burst_end ||
                   rsp_bus.stream_end !== want.stream_end) begin
                  fail_count++;
                  if (rsp_bus.out_word !== want.word)
                     $display("%0t: out_word expected %h got %h", $time, want.word,
                              rsp_bus.out_word);
                  if (rsp_bus.byte_count !== want.count)
                     $display("%0t: byte_count expected %0d got %0d", $time, want.count,
                              rsp_bus.byte_count);
                  if (rsp_bus.burst_end !== want.burst_end)
                     $display("%0t: burst_end expected %b got %b", $time, want.burst_end,
                              rsp_bus.burst_end);
                  if (rsp_bus.stream_end !== want.stream_end)
                     $display("%0t: stream_end expected %b got %b", $time,
                              want.stream_end, rsp_bus.stream_end);
               end
            end
         end
      end
      pending = expected_words.size();
   end

endmodule

// ===== tb/byte_rle_encoder_test.sv =====
// stimulus, clock, reset and verdict for the byte run-length encoder
`timescale 1ns / 1ps
module byte_rle_encoder_test;
   import brle_pkg::*;

   localparam int LANE_BYTES  = 8;
   localparam int HALF_PERIOD = 10;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int END_CYCLES  = 40;

   logic              clock = 1'b0;
   logic              reset;
   int                fail_count;
   int                pending;
   int                cycle_count = 0;
   int                idle_pct = 0;
   int                stall_pct = 0;
   int                hold_asks = 0;
   int                hold_done = 0;
   int                hold_left = 0;
   logic [BYTE_W-1:0] last_sent = '0;

   brle_req_if req_bus ();
   brle_rsp_if rsp_bus ();

   byte_rle_encoder #(.LANE_BYTES(LANE_BYTES)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   byte_rle_encoder_check #(.LANE_BYTES(LANE_BYTES)) code_check (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #HALF_PERIOD clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // result side: random stalls, plus long hold-offs on request
   initial begin
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_done != hold_asks) begin
            hold_done++;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // offer one byte after random idle cycles; valid stays high on return
   task automatic send_byte(input logic [BYTE_W-1:0] value, input logic last);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= value;
      req_bus.stream_last <= last;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      last_sent = value;
   endtask

   task automatic send_run(input logic [BYTE_W-1:0] value, input int len, input logic last);
      for (int i = 0; i < len; i++)
         send_byte(value, last && i == len - 1);
   endtask

   // no two neighbors equal, so the group stays literal
   task automatic send_literals(input int len, input logic last);
      logic [BYTE_W-1:0] b;
      b = last_sent;
      for (int i = 0; i < len; i++) begin
         b = b ^ 8'($urandom_range(1, 255));
         send_byte(b, last && i == len - 1);
      end
   endtask

   // two-value noise: pairs, triples and broken runs, stray stream ends
   task automatic send_noise(input int len, input logic last);
      logic [BYTE_W-1:0] a;
      logic [BYTE_W-1:0] c;
      a = 8'($urandom_range(0, 255));
      c = 8'($urandom_range(0, 255));
      for (int i = 0; i < len; i++)
         send_byte($urandom_range(0, 1) ? a : c,
                   (last && i == len - 1) || $urandom_range(0, 15) == 0);
   endtask

   // mix of runs, literal stretches and noise, trimmed to the budget
   task automatic send_segments(input int budget);
      int   sent;
      int   len;
      int   kind;
      logic close;
      sent = 0;
      while (sent < budget) begin
         kind = $urandom_range(0, 9);
         close = ($urandom_range(0, 3) == 0);
         if (kind < 4)
            len = $urandom_range(1, 12);
         else if (kind < 7)
            len = $urandom_range(1, 16);
         else
            len = $urandom_range(1, 10);
         if (len > budget - sent)
            len = budget - sent;
         if (kind < 4)
            send_run(8'($urandom_range(0, 255)), len, close);
         else if (kind < 7)
            send_literals(len, close);
         else
            send_noise(len, close);
         sent += len;
      end
   endtask

   // sender pauses until every expected word has arrived
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (pending != 0);
      @(posedge clock);
   endtask

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.stream_last <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // single byte stream, lowest value
      send_byte(8'h00, 1'b1);
      // three equal bytes at the start of a group, flushed by stream end
      send_run(8'hFF, 3, 1'b1);
      // literals closed by a run, run broken by a different byte
      send_byte(8'h12, 1'b0);
      send_run(8'h34, 3, 1'b0);
      send_byte(8'h56, 1'b1);
      // pair left as literals at stream end
      send_run(8'hA5, 2, 1'b1);
      // plain literal group with the top bit patterns
      send_byte(8'h80, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h01, 1'b1);
      // run broken on the final byte
      send_run(8'h0F, 4, 1'b0);
      send_byte(8'hF0, 1'b1);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 46;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 46;
            end
            default: begin
               idle_pct = 21;
               stall_pct = 21;
            end
         endcase
         // run reaching its limit, then one byte more
         if (phase == 1) begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
            send_run(last_sent ^ 8'($urandom_range(1, 255)), RUN_MAX + 1, 1'b0);
         end
         // full literal group while the output is held off
         if (phase == 2) begin
            hold_asks++;
            send_byte(8'($urandom_range(0, 255)), 1'b1);
            send_literals(LITERAL_DEPTH + 1, 1'b0);
         end
         send_segments(PHASE_ITEMS / 2);
         if (phase == 3)
            wait_drained();
         send_segments(PHASE_ITEMS / 2);
         wait_drained();
      end

      // close the stream and let the block settle
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      wait_drained();
      repeat (END_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/brle_pkg.sv
src/brle_chan_if.sv
src/brle_ctrl.sv
src/brle_dp.sv
src/byte_rle_encoder.sv
src/brle_checker.sv
tb/byte_rle_encoder_check.sv
tb/byte_rle_encoder_test.sv
